@@ hw/rtl/plsu_pkg.sv @@
// ----------------------------------------------------------------------------
// plsu_pkg
// shared types and constants for the positional list store
// ----------------------------------------------------------------------------
package plsu_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int FUNC_W       = 3;
    localparam int POS_W        = 7;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 48;

    // operation codes carried in the slave tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_END   = 3'd1,
        FN_INS_AT    = 3'd2,
        FN_REM_FRONT = 3'd3,
        FN_REM_END   = 3'd4,
        FN_REM_AT    = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // what every cell does at an accepted word
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic     en;
        cell_op_t op;
        logic [KEY_W-1:0] key;
    } cell_cmd_t;

endpackage

@@ hw/rtl/plsu_cell.sv @@
// ----------------------------------------------------------------------------
// plsu_cell
// one slot of the list: holds a key, shifts with its neighbours
// ----------------------------------------------------------------------------
module plsu_cell #(
    parameter int IDX_W = 7,
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  plsu_pkg::cell_cmd_t        cmd,
    input  logic [IDX_W-1:0]           at_idx,
    input  logic [plsu_pkg::KEY_W-1:0] left_key,
    input  logic [plsu_pkg::KEY_W-1:0] right_key,
    output logic [plsu_pkg::KEY_W-1:0] key,
    output logic [plsu_pkg::KEY_W-1:0] hit_key
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [plsu_pkg::KEY_W-1:0] key_reg;
    logic [plsu_pkg::KEY_W-1:0] key_next;
    logic                       is_at;
    logic                       past_at;

    assign is_at   = (MY_IDX == at_idx);
    assign past_at = (MY_IDX > at_idx);

    always_comb
    begin
        key_next = key_reg;
        if (cmd.en)
        begin
            unique case (cmd.op)
                plsu_pkg::CELL_INSERT:
                begin
                    if (is_at)
                        key_next = cmd.key;
                    else if (past_at)
                        key_next = left_key;
                end
                plsu_pkg::CELL_REMOVE:
                begin
                    if (is_at || past_at)
                        key_next = right_key;
                end
                default: key_next = key_reg;
            endcase
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key     = key_reg;
    assign hit_key = is_at ? key_reg : '0;

endmodule

@@ hw/rtl/positional_list_store_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_store_unit
// ordered list of 32-bit keys with insert and remove at front, end or index
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  s_*       in   s_tvalid/tready   tuser: func; tdata: position, entry_key
//  m_*       out  m_tvalid/tready   tdata: status, removed_valid,
//                                   removed_key, entry_count
//
//  one word per cycle when the output register is free: the decision, the
//  shift of the whole cell row and the capture of the result all happen at
//  the accepting edge; the result sits in an output register, and a new word
//  is taken whenever that register is empty or being drained in the same cycle
//  a master-side stall holds the slave side off only while the result waits
//  reset clears the entry count and the output valid; slot contents are not
//  cleared, only slots below the count are ever read
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
    parameter int CAPACITY = plsu_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [6:0] position, [38:7] entry_key, [39] zero
    input  logic [plsu_pkg::IN_DATA_W-1:0]  s_tdata,
    // [2:0] func
    input  logic [plsu_pkg::FUNC_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [2] removed_valid, [34:3] removed_key,
    // [41:35] entry_count, [47:42] zero
    output logic [plsu_pkg::OUT_DATA_W-1:0] m_tdata
);

    // count needs to hold the capacity itself
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // common width for comparing positions against the count
    localparam int CMP_W = (CNT_W > plsu_pkg::POS_W) ? CNT_W : plsu_pkg::POS_W;
    localparam int KW    = plsu_pkg::KEY_W;

    // input word fields
    plsu_pkg::func_t            func;
    logic [plsu_pkg::POS_W-1:0] position;
    logic [KW-1:0]              entry_key;

    assign func      = plsu_pkg::func_t'(s_tuser);
    assign position  = s_tdata[plsu_pkg::POS_W-1:0];
    assign entry_key = s_tdata[plsu_pkg::POS_W +: KW];

    // control state
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [plsu_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [plsu_pkg::OUT_DATA_W-1:0] out_data_next;

    logic accept;
    logic out_take;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign out_take = m_tvalid_reg && m_tready;

    // operation decode
    logic [CMP_W-1:0]    occ_x;
    logic [CMP_W-1:0]    pos_x;
    logic [CMP_W-1:0]    at_idx;
    logic                is_full;
    logic                is_empty;
    plsu_pkg::status_t   status;
    logic                rem_valid;
    logic [KW-1:0]       rem_key;
    logic [CNT_W-1:0]    occ_after;
    plsu_pkg::cell_cmd_t cmd;

    // cell row
    logic [KW-1:0] cell_key [CAPACITY];
    logic [KW-1:0] cell_hit [CAPACITY];
    logic [KW-1:0] hit_or;

    assign occ_x    = CMP_W'(occ_reg);
    assign pos_x    = CMP_W'(position);
    assign is_full  = (occ_reg == CNT_W'(CAPACITY));
    assign is_empty = (occ_reg == '0);

    // key of the addressed slot, taken before the row shifts
    always_comb
    begin
        hit_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            hit_or = hit_or | cell_hit[i];
    end

    always_comb
    begin
        at_idx    = '0;
        status    = plsu_pkg::ST_OK;
        rem_valid = 1'b0;
        rem_key   = '0;
        occ_after = occ_reg;
        cmd.en    = 1'b0;
        cmd.op    = plsu_pkg::CELL_HOLD;
        cmd.key   = entry_key;

        unique case (func) inside
            plsu_pkg::FN_INS_FRONT,
            plsu_pkg::FN_INS_END,
            plsu_pkg::FN_INS_AT:
            begin
                if (func == plsu_pkg::FN_INS_FRONT)
                    at_idx = '0;
                else if (func == plsu_pkg::FN_INS_END)
                    at_idx = occ_x;
                else
                    at_idx = pos_x;

                if (at_idx > occ_x)
                    status = plsu_pkg::ST_RANGE;
                else if (is_full)
                    status = plsu_pkg::ST_FULL;
                else
                begin
                    cmd.op    = plsu_pkg::CELL_INSERT;
                    occ_after = occ_reg + CNT_W'(1);
                end
            end
            plsu_pkg::FN_REM_FRONT,
            plsu_pkg::FN_REM_END,
            plsu_pkg::FN_REM_AT:
            begin
                if (func == plsu_pkg::FN_REM_FRONT)
                    at_idx = '0;
                else if (func == plsu_pkg::FN_REM_END)
                    at_idx = occ_x - CMP_W'(1);
                else
                    at_idx = pos_x;

                if (is_empty)
                    status = plsu_pkg::ST_EMPTY;
                else if (at_idx >= occ_x)
                    status = plsu_pkg::ST_RANGE;
                else
                begin
                    cmd.op    = plsu_pkg::CELL_REMOVE;
                    rem_valid = 1'b1;
                    rem_key   = hit_or;
                    occ_after = occ_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // undefined codes leave everything alone
                status = plsu_pkg::ST_OK;
            end
        endcase

        cmd.en = accept;
    end

    // row of slots, slot 0 is the list front
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [KW-1:0] left_in;
        logic [KW-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = cell_key[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_key[g];
        end
        else
        begin : g_mid_r
            assign right_in = cell_key[g+1];
        end

        plsu_cell #(
            .IDX_W (CMP_W),
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .at_idx    (at_idx),
            .left_key  (left_in),
            .right_key (right_in),
            .key       (cell_key[g]),
            .hit_key   (cell_hit[g])
        );
    end

    // next state of count and output register
    always_comb
    begin
        occ_next      = occ_reg;
        m_tvalid_next = m_tvalid_reg;
        out_data_next = out_data_reg;
        if (out_take)
            m_tvalid_next = 1'b0;
        if (accept)
        begin
            occ_next      = occ_after;
            m_tvalid_next = 1'b1;
            out_data_next = {6'd0,
                             plsu_pkg::COUNT_W'(occ_after),
                             rem_key,
                             rem_valid,
                             status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // count never passes the capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a successful insert grows the list by exactly one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == plsu_pkg::CELL_INSERT) |=>
            (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // a successful remove shrinks the list by exactly one
    a_rem_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == plsu_pkg::CELL_REMOVE) |=>
            (occ_reg == $past(occ_reg) - CNT_W'(1)))
        else $error("remove did not shrink the list by one");

    // removed key is zero whenever the removed flag is clear
    a_rem_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !out_data_reg[2]) |-> (out_data_reg[34:3] == '0))
        else $error("removed key set without removed flag");
`endif

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks positional_list_store_unit against an in-bench list predictor
//
// words are pushed through the slave stream in random bursts while the
// master side stalls on its own pattern; every accepted word updates a
// queue-based copy of the list and the expected result word is checked
// field by field against what leaves the master stream
// ----------------------------------------------------------------------------
module testbench;

    // func codes outside the defined set, the block must ignore them
    localparam logic [plsu_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [plsu_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;
    localparam logic [plsu_pkg::POS_W-1:0]  POS_TOP     = '1;
    localparam logic [plsu_pkg::KEY_W-1:0]  KEY_ONES    = '1;
    localparam int                          KEY_W       = plsu_pkg::KEY_W;
    localparam int                          FUNC_W      = plsu_pkg::FUNC_W;
    localparam int                          POS_W       = plsu_pkg::POS_W;
    localparam int                          COUNT_W     = plsu_pkg::COUNT_W;
    localparam int                          CAP         = plsu_pkg::CAPACITY_DEF;

    // ready patterns of the result consumer
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // one expected result word, as the block reports it
    typedef struct packed {
        plsu_pkg::status_t  status;
        logic               removed_valid;
        logic [KEY_W-1:0]   removed_key;
        logic [COUNT_W-1:0] entry_count;
    } list_result_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // [6:0] position, [38:7] entry_key, [39] zero
    logic [plsu_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    // [2:0] func
    logic [FUNC_W-1:0]               s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [1:0] status, [2] removed_valid, [34:3] removed_key,
    // [41:35] entry_count, [47:42] zero
    logic [plsu_pkg::OUT_DATA_W-1:0] m_tdata;

    // predicted list contents, front of the list at index 0
    logic [KEY_W-1:0] list_keys[$];
    // result words still owed by the block, oldest first
    list_result_t     pending_results[$];

    int unsigned mismatch_count = 0;
    int          burst_left     = 0;
    logic        valid_held     = 1'b0;
    rx_mode_t    rx_mode        = RX_FREE;
    int unsigned rx_run         = 0;
    int unsigned rx_stall       = 0;
    list_result_t got_word;

    positional_list_store_unit #(
        .CAPACITY (CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // generous overall limit, far above the slowest legal run
    initial
    begin
        #3000000;
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // list predictor: applies one operation, returns the result word
    // ------------------------------------------------------------------
    function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] fn,
                                                   input logic [POS_W-1:0]  pos,
                                                   input logic [KEY_W-1:0]  key);
        list_result_t res;
        int unsigned  held;
        int unsigned  at;
        res  = '0;
        held = list_keys.size();
        at   = 0;
        case (fn) inside
            plsu_pkg::FN_INS_FRONT, plsu_pkg::FN_INS_END, plsu_pkg::FN_INS_AT:
            begin
                if (fn == plsu_pkg::FN_INS_END)
                    at = held;
                else if (fn == plsu_pkg::FN_INS_AT)
                    at = pos;
                // range beats full, a position equal to the count appends
                if (at > held)
                    res.status = plsu_pkg::ST_RANGE;
                else if (held >= CAP)
                    res.status = plsu_pkg::ST_FULL;
                else
                    list_keys.insert(at, key);
            end
            plsu_pkg::FN_REM_FRONT, plsu_pkg::FN_REM_END, plsu_pkg::FN_REM_AT:
            begin
                // an empty list is reported before any range check
                if (held == 0)
                    res.status = plsu_pkg::ST_EMPTY;
                else
                begin
                    if (fn == plsu_pkg::FN_REM_END)
                        at = held - 1;
                    else if (fn == plsu_pkg::FN_REM_AT)
                        at = pos;
                    if (at >= held)
                        res.status = plsu_pkg::ST_RANGE;
                    else
                    begin
                        res.removed_key   = list_keys[at];
                        res.removed_valid = 1'b1;
                        list_keys.delete(at);
                    end
                end
            end
            default:
                ; // spare codes leave everything alone
        endcase
        res.entry_count = COUNT_W'(list_keys.size());
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [FUNC_W-1:0] pick_insert();
        case ($urandom_range(0, 2))
            0:       return plsu_pkg::FN_INS_FRONT;
            1:       return plsu_pkg::FN_INS_END;
            default: return plsu_pkg::FN_INS_AT;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_remove();
        case ($urandom_range(0, 2))
            0:       return plsu_pkg::FN_REM_FRONT;
            1:       return plsu_pkg::FN_REM_END;
            default: return plsu_pkg::FN_REM_AT;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_spare();
        return ($urandom_range(0, 1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
    endfunction

    // mostly near the current count, so both edges of the range get hit
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned held;
        int unsigned roll;
        held = list_keys.size();
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return POS_W'($urandom_range(0, held + 1));
        else if (roll < 80)
            return POS_W'((held == 0) ? 0 : held - 1 + $urandom_range(0, 1));
        else
            return POS_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return KEY_ONES;
        else
            return $urandom;
    endfunction

    // mostly short bursts, now and then a long run with no gaps at all
    function automatic int next_burst();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(50, 150);
        return $urandom_range(1, 12);
    endfunction

    task automatic drop_valid();
        if (valid_held)
        begin
            s_tvalid   <= 1'b0;
            valid_held  = 1'b0;
        end
    endtask

    // one word on the slave stream; the prediction is taken at acceptance
    task automatic send_word(input logic [FUNC_W-1:0] fn,
                             input logic [POS_W-1:0]  pos,
                             input logic [KEY_W-1:0]  key);
        s_tvalid   <= 1'b1;
        s_tuser    <= fn;
        s_tdata    <= {1'b0, key, pos};
        valid_held  = 1'b1;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        pending_results.push_back(apply_list_op(fn, pos, key));
        burst_left--;
        if (burst_left <= 0)
        begin
            drop_valid();
            repeat ($urandom_range(1, 7))
                @(posedge clk);
            burst_left = next_burst();
        end
    endtask

    task automatic send_random(input logic [FUNC_W-1:0] fn);
        send_word(fn, pick_position(), pick_key());
    endtask

    // hold the sender back until every owed result has been seen
    task automatic wait_until_drained();
        drop_valid();
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        burst_left = next_burst();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every removal on an empty list, out of range inserts, spare codes
    task automatic test_empty_list();
        send_word(plsu_pkg::FN_REM_FRONT, '0, KEY_ONES);
        send_word(plsu_pkg::FN_REM_END, POS_TOP, '0);
        send_word(plsu_pkg::FN_REM_AT, POS_TOP, KEY_ONES);
        send_word(plsu_pkg::FN_INS_AT, 7'd1, 32'h0bad_f00d);
        send_word(plsu_pkg::FN_INS_AT, POS_TOP, KEY_ONES);
        send_word(FN_SPARE_LO, POS_TOP, KEY_ONES);
        send_word(FN_SPARE_HI, '0, '0);
    endtask

    // a short list built and taken apart through every operation
    task automatic test_short_list();
        send_word(plsu_pkg::FN_INS_AT, '0, '0);     // position equal to count appends
        send_word(plsu_pkg::FN_INS_END, POS_TOP, KEY_ONES);
        send_word(plsu_pkg::FN_INS_FRONT, POS_TOP, 32'h8000_0001);
        send_word(plsu_pkg::FN_INS_AT, 7'd1, 32'h1234_5678);
        send_word(plsu_pkg::FN_INS_AT, 7'd4, 32'h7fff_fffe); // append at the count again
        send_word(plsu_pkg::FN_REM_AT, 7'd5, '0);   // one past the last entry
        send_word(plsu_pkg::FN_REM_AT, POS_TOP, '0);
        send_word(plsu_pkg::FN_REM_AT, 7'd2, KEY_ONES);
        send_word(plsu_pkg::FN_REM_END, '0, '0);
        send_word(plsu_pkg::FN_REM_FRONT, '0, '0);
        send_word(FN_SPARE_HI, 7'd1, KEY_ONES);
        send_word(plsu_pkg::FN_REM_AT, '0, '0);
        send_word(plsu_pkg::FN_REM_END, '0, '0);    // list becomes empty here
        send_word(plsu_pkg::FN_REM_END, '0, '0);
        send_word(plsu_pkg::FN_REM_AT, '0, '0);
    endtask

    // fill to capacity, probe the full list, then empty it again
    task automatic test_fill_and_drain(input int rounds);
        int unsigned roll;
        repeat (rounds)
        begin
            while (list_keys.size() < CAP)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    send_random(pick_insert());
                else if (roll < 96)
                    send_random(pick_remove());
                else
                    send_random(pick_spare());
            end
            // full list: range is checked ahead of full
            send_word(plsu_pkg::FN_INS_FRONT, pick_position(), pick_key());
            send_word(plsu_pkg::FN_INS_END, pick_position(), pick_key());
            send_word(plsu_pkg::FN_INS_AT, POS_W'(CAP), pick_key());
            send_word(plsu_pkg::FN_INS_AT, POS_W'(CAP + 1), pick_key());
            send_word(plsu_pkg::FN_INS_AT, POS_TOP, pick_key());
            send_word(plsu_pkg::FN_REM_AT, POS_W'(CAP), pick_key());
            while (list_keys.size() > 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    send_random(pick_remove());
                else if (roll < 96)
                    send_random(pick_insert());
                else
                    send_random(pick_spare());
            end
            repeat (3)
                send_random(pick_remove());
        end
    endtask

    // random walk whose fill level drifts towards a moving target
    task automatic test_random_ops(input int words);
        int unsigned target;
        int unsigned roll;
        int unsigned lean;
        target = 0;
        for (int i = 0; i < words; i++)
        begin
            if (i % 50 == 0)
                target = $urandom_range(0, CAP);
            lean = (list_keys.size() < target) ? 70 : 30;
            roll = $urandom_range(0, 99);
            if (roll < 6)
                send_random(pick_spare());
            else if ($urandom_range(0, 99) < lean)
                send_random(pick_insert());
            else
                send_random(pick_remove());
        end
    endtask

    // ------------------------------------------------------------------
    // result consumer: ready follows a pattern that changes every so often
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_run  = $urandom_range(20, 200);
        end
        else
            rx_run--;
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                // stall of random length, possibly none, then a single ready cycle
                if (rx_stall == 0)
                begin
                    m_tready <= 1'b1;
                    rx_stall  = $urandom_range(0, 15);
                end
                else
                begin
                    m_tready <= 1'b0;
                    rx_stall--;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // result checker: every accepted result word against the oldest owed one
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string field,
                                 input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, field, want, seen);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unowed result word", '0, m_tdata[KEY_W-1:0]);
            else
            begin
                got_word = pending_results.pop_front();
                if (m_tdata[1:0] !== got_word.status)
                    note_mismatch("status", KEY_W'(got_word.status),
                                  KEY_W'(m_tdata[1:0]));
                if (m_tdata[2] !== got_word.removed_valid)
                    note_mismatch("removed_valid", KEY_W'(got_word.removed_valid),
                                  KEY_W'(m_tdata[2]));
                if (m_tdata[34:3] !== got_word.removed_key)
                    note_mismatch("removed_key", got_word.removed_key, m_tdata[34:3]);
                if (m_tdata[41:35] !== got_word.entry_count)
                    note_mismatch("entry_count", KEY_W'(got_word.entry_count),
                                  KEY_W'(m_tdata[41:35]));
                if (m_tdata[47:42] !== '0)
                    note_mismatch("padding", '0, KEY_W'(m_tdata[47:42]));
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);
        burst_left = next_burst();

        test_empty_list();
        test_short_list();
        wait_until_drained();
        test_fill_and_drain(3);
        wait_until_drained();
        test_random_ops(750);

        // let the last words out, then wait quietly for strays
        wait_until_drained();
        repeat (8)
            @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/plsu_pkg.sv
hw/rtl/plsu_cell.sv
hw/rtl/positional_list_store_unit.sv
bench/testbench.sv
